// ----- rtl/irdig_pkg.sv -----
`default_nettype none

package irdig_pkg;

	// field widths
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned RADIX_W = 6;
	localparam int unsigned MIND_W  = 6;
	localparam int unsigned CHAR_W  = 7;

	// quotient bits resolved per cycle by the shared divider
	localparam int unsigned BITS_PER_STEP = 4;

	// default saturation bound for the minimum digit count
	localparam int unsigned MAX_MIN_DIGITS_DEF = 32;

	// valid radix range
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_QUESTION = 7'd63;
	localparam logic [CHAR_W-1:0] CHAR_MINUS    = 7'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_LETTER_A = 7'd65;

	// digit value to its ascii character, 0-9 then A-Z
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] code;
		if (d < 6'd10) begin
			code = CHAR_ZERO + {1'b0, d};
		end else begin
			code = CHAR_LETTER_A + {1'b0, d} - 7'd10;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_radix_digits_top.sv -----
`default_nettype none

// Integer to radix string converter. A conversion is started by a beat on
// start while busy is low; value, radix and min_digits are sampled then. The
// characters come out most significant first, one per cycle on strobe, with
// last set on the final one; the receiver cannot stall, so it must take a
// beat in every cycle that strobe is high. An invalid radix (outside 2..36)
// gives a single '?' in the cycle after start and leaves the block free at once.
// Otherwise a negative value emits '-' first, then '0' padding up to
// min_digits (saturated to MAX_MIN_DIGITS), then the digits. The digits
// are produced by one shared restoring divider that retires four quotient
// bits per cycle, one whole division per digit, all before the first
// character; a zero value gives a single '0', and the longest conversion
// is radix 2 with the most negative value.
module integer_to_radix_digits_top #(
	parameter int unsigned MAX_MIN_DIGITS = irdig_pkg::MAX_MIN_DIGITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire  [irdig_pkg::VALUE_W-1:0]     value,
	input  wire  [irdig_pkg::RADIX_W-1:0]     radix,
	input  wire  [irdig_pkg::MIND_W-1:0]      min_digits,
	output logic                              strobe,
	output logic [irdig_pkg::CHAR_W-1:0]      char_code,
	output logic                              last
);
	import irdig_pkg::*;

	// digit store depth: one entry per bit of the magnitude covers radix 2
	localparam int unsigned NDIG     = VALUE_W;
	localparam int unsigned IDX_W    = $clog2(NDIG);
	localparam int unsigned CNT_W    = IDX_W + 1;
	localparam int unsigned STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int unsigned STEP_W   = $clog2(STEPS);
	// padding count holds any min_digits value
	localparam int unsigned PAD_W    = MIND_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_PAD,
		ST_DIG
	} state_t;

	state_t                state_q;
	logic [VALUE_W-1:0]    quo_q;        // dividend shifting out, quotient shifting in
	logic [RADIX_W-1:0]    rem_q;        // partial remainder, always below radix
	logic [RADIX_W-1:0]    radix_q;
	logic [STEP_W-1:0]     step_q;       // which nibble of the current division
	logic [CNT_W-1:0]      ndig_q;       // digits found so far
	logic [IDX_W-1:0]      idx_q;        // digit being emitted, counts down
	logic [PAD_W-1:0]      min_q;        // saturated minimum digit count
	logic [PAD_W-1:0]      pad_q;        // leading zeros still to send
	logic                  neg_q;
	logic                  strobe_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	// digit store, least significant digit at entry 0
	logic [RADIX_W-1:0]    digits_mem [NDIG];

	// next-state values of the shared divider
	logic [VALUE_W-1:0]    quo_d;
	logic [RADIX_W-1:0]    rem_d;
	logic [RADIX_W:0]      trial;

	// accept decode and start-time values
	logic                  accept;
	logic                  radix_bad;
	logic [VALUE_W-1:0]    mag;
	logic [PAD_W-1:0]      min_sat;

	// end-of-division decode
	logic                  dig_done;
	logic [CNT_W-1:0]      ndig_d;
	logic [PAD_W-1:0]      pad_d;

	assign accept    = start && (state_q == ST_IDLE);
	assign radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
	// two's complement magnitude; the most negative value maps to 2^31 unsigned
	assign mag       = value[VALUE_W-1] ? (~value + 32'd1) : value;
	assign min_sat   = ({1'b0, min_digits} > PAD_W'(MAX_MIN_DIGITS))
		? PAD_W'(MAX_MIN_DIGITS) : {1'b0, min_digits};

	// shared divider: four restoring steps on a narrow remainder per cycle
	always_comb begin
		quo_d = quo_q;
		rem_d = rem_q;
		trial = '0;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			trial = {rem_d, quo_d[VALUE_W-1]};
			quo_d = {quo_d[VALUE_W-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				rem_d    = RADIX_W'(trial - {1'b0, radix_q});
				quo_d[0] = 1'b1;
			end else begin
				rem_d = trial[RADIX_W-1:0];
			end
		end
	end

	assign dig_done = (step_q == STEP_W'(STEPS - 1));
	assign ndig_d   = ndig_q + CNT_W'(1);
	// padding only when the minimum exceeds the natural digit count
	assign pad_d    = (min_q > PAD_W'(ndig_d)) ? (min_q - PAD_W'(ndig_d)) : '0;

	// remainder of a finished division is the next digit up
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && dig_done) begin
			digits_mem[ndig_q[IDX_W-1:0]] <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			quo_q    <= '0;
			rem_q    <= '0;
			radix_q  <= '0;
			step_q   <= '0;
			ndig_q   <= '0;
			idx_q    <= '0;
			min_q    <= '0;
			pad_q    <= '0;
			neg_q    <= 1'b0;
			strobe_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (radix_bad) begin
							// single '?' beat, block stays free
							strobe_q <= 1'b1;
							char_q   <= CHAR_QUESTION;
							last_q   <= 1'b1;
						end else begin
							quo_q   <= mag;
							rem_q   <= '0;
							radix_q <= radix;
							step_q  <= '0;
							ndig_q  <= '0;
							min_q   <= min_sat;
							neg_q   <= value[VALUE_W-1];
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					quo_q  <= quo_d;
					rem_q  <= rem_d;
					step_q <= step_q + STEP_W'(1);
					if (dig_done) begin
						// digit stored; restart on the quotient unless it is zero
						rem_q  <= '0;
						ndig_q <= ndig_d;
						if (quo_d == '0) begin
							idx_q <= ndig_q[IDX_W-1:0];
							pad_q <= pad_d;
							if (neg_q) begin
								state_q <= ST_SIGN;
							end else if (pad_d != '0) begin
								state_q <= ST_PAD;
							end else begin
								state_q <= ST_DIG;
							end
						end
					end
				end
				ST_SIGN: begin
					// at least one digit always follows the sign
					strobe_q <= 1'b1;
					char_q   <= CHAR_MINUS;
					state_q  <= (pad_q != '0) ? ST_PAD : ST_DIG;
				end
				ST_PAD: begin
					strobe_q <= 1'b1;
					char_q   <= CHAR_ZERO;
					pad_q    <= pad_q - PAD_W'(1);
					if (pad_q == PAD_W'(1)) begin
						state_q <= ST_DIG;
					end
				end
				ST_DIG: begin
					// most significant digit first, least significant is last
					strobe_q <= 1'b1;
					char_q   <= digit_char(digits_mem[idx_q]);
					idx_q    <= idx_q - IDX_W'(1);
					if (idx_q == '0) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

	// a valid radix always starts a multi-cycle conversion
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !radix_bad) |=> busy)
		else $error("valid conversion did not start");

	// a character that is not last only appears mid-conversion
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final beat outside a conversion");

	// the conversion ends exactly with its final beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("conversion ended without a final beat");

	// '?' is always a lone, final beat and never part of a conversion
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && char_code == CHAR_QUESTION) |-> (last && !busy))
		else $error("bad-radix beat inside a conversion");

endmodule

`default_nettype wire
